### hdl/rds_pkg.sv
package rds_pkg;

  localparam logic signed [31:0] DEAD_ZONE = 32'sd655;
  // 2^32 / (2 pi), rounded
  localparam logic [32:0] ANG_SCALE = 33'd683565276;

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_END = 4'd12;

  typedef enum logic [2:0] {
    REG_INV_INERTIA = 3'd0,
    REG_VISCOUS     = 3'd1,
    REG_COULOMB     = 3'd2,
    REG_POLE_PAIRS  = 3'd3,
    REG_EXTRA_LOAD  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_VISC,
    MUL_NET,
    MUL_ACC,
    MUL_SPDMAG,
    MUL_MHI,
    MUL_MLO,
    MUL_ELEC
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_NET,
    OP_ACC,
    OP_SPEED,
    OP_SIGN,
    OP_MLO,
    OP_HI,
    OP_ANGLE,
    OP_ELEC
  } alu_op_t;

  typedef struct packed {
    logic [31:0]        inv_inertia;
    logic [30:0]        viscous_friction;
    logic [30:0]        coulomb_friction;
    logic [6:0]         pole_pairs;
    logic signed [31:0] extra_load_torque;
  } cfg_t;

  typedef struct packed {
    logic     start;
    mul_sel_t mul;
    alu_op_t  op;
  } ctrl_t;

  typedef struct packed {
    mul_sel_t mul;
    alu_op_t  op;
    logic     jmp_inv_zero;
    step_t    target;
    logic     last;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = '{mul: MUL_NONE, op: OP_NOP, jmp_inv_zero: 1'b0, target: STEP_END, last: 1'b0};
    unique case (step)
      4'd0:  begin
        uc.mul = MUL_VISC;
        uc.jmp_inv_zero = 1'b1;
      end
      4'd1:  uc.op = OP_NET;
      4'd2:  uc.mul = MUL_NET;
      4'd3:  uc.op = OP_ACC;
      4'd4:  uc.mul = MUL_ACC;
      4'd5:  uc.op = OP_SPEED;
      4'd6:  begin
        uc.mul = MUL_SPDMAG;
        uc.op = OP_SIGN;
      end
      4'd7:  begin
        uc.mul = MUL_MHI;
        uc.op = OP_MLO;
      end
      4'd8:  begin
        uc.mul = MUL_MLO;
        uc.op = OP_HI;
      end
      4'd9:  uc.op = OP_ANGLE;
      4'd10: uc.mul = MUL_ELEC;
      4'd11: uc.op = OP_ELEC;
      default: uc.last = 1'b1;
    endcase
    return uc;
  endfunction

endpackage

### hdl/rds_datapath.sv
module rds_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  rds_pkg::ctrl_t     ctrl,
  input  rds_pkg::cfg_t      cfg,
  input  logic signed [31:0] em_torque,
  input  logic signed [31:0] load_torque,
  input  logic [31:0]        time_step,
  output logic signed [31:0] speed,
  output logic [31:0]        angle,
  output logic [31:0]        elec_angle,
  output logic signed [31:0] accel
);

  logic signed [33:0] drive_r;
  logic [31:0]        dt_r;
  logic signed [65:0] prod_r;
  logic [31:0]        mlo_r;
  logic [63:0]        hi_r;
  logic               neg_r;
  logic signed [31:0] net_r;
  logic signed [31:0] speed_r;
  logic signed [31:0] accel_r;
  logic [31:0]        angle_r;
  logic [31:0]        elec_r;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_full;
  logic [31:0]        spd_mag;
  logic signed [51:0] coul_term;
  logic signed [51:0] net_w;
  logic signed [51:0] spd_sum;
  logic signed [31:0] spd_sat;
  logic signed [33:0] coul_s;
  logic               stick;
  logic [63:0]        ang_sum;
  logic [31:0]        turns;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    logic signed [31:0] r;
    if ((&x[51:31]) || !(|x[51:31])) begin
      r = x[31:0];
    end else if (x[51]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  assign spd_mag = speed_r[31] ? (32'd0 - speed_r) : speed_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.mul)
      rds_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      rds_pkg::MUL_VISC: begin
        mul_a = {2'b00, cfg.viscous_friction};
        mul_b = {speed_r[31], speed_r};
      end
      rds_pkg::MUL_NET: begin
        mul_a = {net_r[31], net_r};
        mul_b = {1'b0, cfg.inv_inertia};
      end
      rds_pkg::MUL_ACC: begin
        mul_a = {accel_r[31], accel_r};
        mul_b = {1'b0, dt_r};
      end
      rds_pkg::MUL_SPDMAG: begin
        mul_a = {1'b0, spd_mag};
        mul_b = {1'b0, dt_r};
      end
      rds_pkg::MUL_MHI: begin
        mul_a = {1'b0, prod_r[63:32]};
        mul_b = rds_pkg::ANG_SCALE;
      end
      rds_pkg::MUL_MLO: begin
        mul_a = {1'b0, mlo_r};
        mul_b = rds_pkg::ANG_SCALE;
      end
      rds_pkg::MUL_ELEC: begin
        mul_a = {1'b0, angle_r};
        mul_b = {26'd0, cfg.pole_pairs};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // coulomb friction by direction, with dead zone
  always_comb begin
    if (speed_r > rds_pkg::DEAD_ZONE) begin
      coul_term = {21'd0, cfg.coulomb_friction};
    end else if (speed_r < -rds_pkg::DEAD_ZONE) begin
      coul_term = -{21'd0, cfg.coulomb_friction};
    end else begin
      coul_term = '0;
    end
  end

  assign net_w   = {{18{drive_r[33]}}, drive_r} - {{2{prod_r[65]}}, prod_r[65:16]} - coul_term;
  assign spd_sum = {{20{speed_r[31]}}, speed_r} + {{18{prod_r[65]}}, prod_r[65:32]};
  assign spd_sat = sat32(spd_sum);
  assign coul_s  = {3'b000, cfg.coulomb_friction};
  assign stick   = (spd_sat <= rds_pkg::DEAD_ZONE) && (spd_sat >= -rds_pkg::DEAD_ZONE) &&
                   (drive_r <= coul_s) && (drive_r >= -coul_s);

  assign ang_sum = hi_r + {32'd0, prod_r[63:32]};
  assign turns   = ang_sum[47:16];

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      drive_r <= {{2{em_torque[31]}}, em_torque} - {{2{load_torque[31]}}, load_torque}
                 - {{2{cfg.extra_load_torque[31]}}, cfg.extra_load_torque};
      dt_r    <= time_step;
    end
    if (ctrl.mul != rds_pkg::MUL_NONE) begin
      prod_r <= prod_full;
    end
    if (ctrl.op == rds_pkg::OP_SIGN) begin
      neg_r <= speed_r[31];
    end
    if (ctrl.op == rds_pkg::OP_MLO) begin
      mlo_r <= prod_r[31:0];
    end
    if (ctrl.op == rds_pkg::OP_HI) begin
      hi_r <= prod_r[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == rds_pkg::OP_NET) begin
      net_r <= sat32(net_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      accel_r <= '0;
      angle_r <= '0;
      elec_r  <= '0;
    end else begin
      unique case (ctrl.op)
        rds_pkg::OP_ACC: begin
          accel_r <= sat32({{2{prod_r[65]}}, prod_r[65:16]});
        end
        rds_pkg::OP_SPEED: begin
          if (stick) begin
            speed_r <= '0;
            accel_r <= '0;
          end else begin
            speed_r <= spd_sat;
          end
        end
        rds_pkg::OP_ANGLE: begin
          angle_r <= angle_r + (neg_r ? (32'd0 - turns) : turns);
        end
        rds_pkg::OP_ELEC: begin
          elec_r <= prod_r[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign speed      = speed_r;
  assign angle      = angle_r;
  assign elec_angle = elec_r;
  assign accel      = accel_r;

endmodule

### hdl/rotor_dynamics_step_top.sv
// an accepted word runs the microcode from step 0 to STEP_END, then out_valid; step 0 jumps
//   straight to STEP_END while inv_inertia is zero; no new word is taken meanwhile, as the
//   single shared 33x33 multiplier runs the torque, speed, angle and pole-pair products
// a new word is taken while a finished result still waits on the output register
// reset: synchronous, active low; clears speed, angle, acceleration, electrical angle
//   and the registers (pole_pairs to 1)
module rotor_dynamics_step_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_em_torque,
  input  logic signed [31:0] in_load_torque,
  input  logic [31:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rotor_speed,
  output logic [31:0]        out_rotor_angle,
  output logic [31:0]        out_electrical_angle,
  output logic signed [31:0] out_rotor_accel,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  rds_pkg::step_t     step_r, step_nxt;
  rds_pkg::ucode_t    uc;
  rds_pkg::ctrl_t     ctrl;
  rds_pkg::cfg_t      cfg_r;
  logic               out_valid_r, out_valid_nxt;
  logic               in_fire;
  logic               finish;
  logic signed [31:0] dp_speed;
  logic [31:0]        dp_angle;
  logic [31:0]        dp_elec;
  logic signed [31:0] dp_accel;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign uc        = rds_pkg::ucode_rom(step_r);
  // last step waits until the output register is free
  assign finish    = (state_r == ST_RUN) && uc.last && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.start = in_fire;
    ctrl.mul   = rds_pkg::MUL_NONE;
    ctrl.op    = rds_pkg::OP_NOP;
    if (state_r == ST_RUN) begin
      ctrl.mul = uc.mul;
      ctrl.op  = uc.op;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (uc.last) begin
          if (finish) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end
        end else if (uc.jmp_inv_zero && (cfg_r.inv_inertia == '0)) begin
          step_nxt = uc.target;
        end else begin
          step_nxt = step_r + rds_pkg::step_t'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_inertia       <= '0;
      cfg_r.viscous_friction  <= '0;
      cfg_r.coulomb_friction  <= '0;
      cfg_r.pole_pairs        <= 7'd1;
      cfg_r.extra_load_torque <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rds_pkg::REG_INV_INERTIA: cfg_r.inv_inertia       <= cfg_data;
        rds_pkg::REG_VISCOUS:     cfg_r.viscous_friction  <= cfg_data[30:0];
        rds_pkg::REG_COULOMB:     cfg_r.coulomb_friction  <= cfg_data[30:0];
        rds_pkg::REG_POLE_PAIRS:  cfg_r.pole_pairs        <= cfg_data[6:0];
        rds_pkg::REG_EXTRA_LOAD:  cfg_r.extra_load_torque <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rds_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .cfg         (cfg_r),
    .em_torque   (in_em_torque),
    .load_torque (in_load_torque),
    .time_step   (in_time_step),
    .speed       (dp_speed),
    .angle       (dp_angle),
    .elec_angle  (dp_elec),
    .accel       (dp_accel)
  );

  always_ff @(posedge clk) begin
    if (finish) begin
      out_rotor_speed      <= dp_speed;
      out_rotor_angle      <= dp_angle;
      out_electrical_angle <= dp_elec;
      out_rotor_accel      <= dp_accel;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/rds_checker.sv
module rds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_rotor_speed,
  input logic [31:0] out_rotor_angle,
  input logic        cfg_ready
);

  // one word in flight: busy straight after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a step is still running");

  // a new result only appears as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while a step is still running");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rotor_speed)
                                   && $stable(out_rotor_angle)))
    else $error("stalled result changed or dropped");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("register port not ready");

endmodule

bind rotor_dynamics_step_top rds_checker u_rds_checker (.*);
